FILE: rtl/wildcard_byte_signature_scan_unit_assert.svh
// Assertion macros for the wildcard byte signature scan unit.
// No dependencies; included by the top level after its logic.
`ifndef WILDCARD_BYTE_SIGNATURE_SCAN_UNIT_ASSERT_SVH
`define WILDCARD_BYTE_SIGNATURE_SCAN_UNIT_ASSERT_SVH

// same-cycle implication
`define WBSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wbss check failed");

// next-cycle implication
`define WBSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wbss check failed");

`endif

FILE: rtl/wbss_pkg.sv
// Package for the wildcard byte signature scan unit: payload types,
// configuration register indexes and default sizes. No dependencies.
package wbss_pkg;

    localparam int MAX_PATTERN_DEF = 32;
    localparam int OFFSET_BITS_DEF = 32;

    localparam int PATTERN_BYTES  = 32;
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_INDEX_W    = 3;
    localparam int PLEN_W         = 6;
    localparam int MATCH_OFFSET_W = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_0 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_1 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_2 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_3 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WILDCARD_MASK  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       region_last;
    } t_in_item;

    typedef struct packed {
        logic                      found;
        logic [MATCH_OFFSET_W-1:0] match_offset;
    } t_out_item;

endpackage

FILE: rtl/wildcard_byte_signature_scan_unit.sv
// Input transactions pass through the input register, then the result register.
// Throughput: one byte per cycle unless output stalls; window compare is combinational.
// At most one result per region; bytes after a match give no result.
// Reset: synchronous, active low; clears region state, handshake state and config
// (pattern bytes and wildcard mask zero, pattern length one).
// Depends on wbss_pkg and wildcard_byte_signature_scan_unit_assert.svh.
module wildcard_byte_signature_scan_unit
    import wbss_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in_item               i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_item              o_out_data,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int PW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int DW = (OFFSET_BITS > MATCH_OFFSET_W) ? OFFSET_BITS : MATCH_OFFSET_W;

    // configuration
    logic [CFG_DATA_W-1:0]    r_pword [4];
    logic [PATTERN_BYTES-1:0] r_wild;
    logic [PLEN_W-1:0]        r_plen;

    // input stage
    logic     r_in_valid;
    t_in_item r_in;

    // region state
    logic [7:0]             r_window [MAX_PATTERN];
    logic [OFFSET_BITS-1:0] r_seen;
    logic                   r_reported;

    // result stage
    logic      r_out_valid;
    t_out_item r_out;

    logic                   s2_adv;
    logic                   s2_fire;
    logic [LW-1:0]          len_used;
    logic [7:0]             pat_arr  [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] wild_arr;
    logic [7:0]             n_window [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] pos_ok;
    logic [OFFSET_BITS-1:0] n_seen;
    logic                   hit;
    logic [DW-1:0]          diff;

    assign s2_adv      = !r_out_valid || i_out_ready;
    assign s2_fire     = r_in_valid && s2_adv;
    assign o_in_ready  = !r_in_valid || s2_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_pword[k] <= '0;
            end
            r_wild <= '0;
            r_plen <= PLEN_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PATTERN_WORD_0: r_pword[0] <= i_cfg_wdata;
                REG_PATTERN_WORD_1: r_pword[1] <= i_cfg_wdata;
                REG_PATTERN_WORD_2: r_pword[2] <= i_cfg_wdata;
                REG_PATTERN_WORD_3: r_pword[3] <= i_cfg_wdata;
                REG_WILDCARD_MASK:  r_wild     <= i_cfg_wdata[PATTERN_BYTES-1:0];
                REG_PATTERN_LENGTH: r_plen     <= i_cfg_wdata[PLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // pattern positions past the register space are literal zero bytes
    always_comb begin
        for (int p = 0; p < MAX_PATTERN; p++) begin
            if (p < PATTERN_BYTES) begin
                pat_arr[p]  = r_pword[p >> 3][(p & 7) * 8 +: 8];
                wild_arr[p] = r_wild[p];
            end else begin
                pat_arr[p]  = 8'd0;
                wild_arr[p] = 1'b0;
            end
        end
    end

    always_comb begin
        if (r_plen == '0) begin
            len_used = LW'(1);
        end else if (int'(r_plen) > MAX_PATTERN) begin
            len_used = LW'(MAX_PATTERN);
        end else begin
            len_used = LW'(r_plen);
        end
    end

    // window index 0 holds the newest byte; index j pairs with position len-1-j
    always_comb begin
        int            pos;
        logic [PW-1:0] pidx;
        n_window[0] = r_in.data_byte;
        for (int j = 1; j < MAX_PATTERN; j++) begin
            n_window[j] = r_window[j-1];
        end
        for (int j = 0; j < MAX_PATTERN; j++) begin
            pos  = int'(len_used) - 1 - j;
            pidx = PW'(pos);
            if (j >= int'(len_used)) begin
                pos_ok[j] = 1'b1;
            end else begin
                pos_ok[j] = wild_arr[pidx] || (n_window[j] == pat_arr[pidx]);
            end
        end
    end

    always_comb begin
        n_seen = (r_seen == '1) ? r_seen : r_seen + OFFSET_BITS'(1);
        hit    = (n_seen >= OFFSET_BITS'(len_used)) && (&pos_ok);
        diff   = DW'(n_seen) - DW'(len_used);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // only window entries written in the current region are ever compared
    always_ff @(posedge i_clk) begin
        if (s2_fire && !r_reported) begin
            for (int j = 0; j < MAX_PATTERN; j++) begin
                r_window[j] <= n_window[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= '0;
            r_reported <= 1'b0;
        end else if (s2_fire) begin
            if (r_in.region_last) begin
                r_seen     <= '0;
                r_reported <= 1'b0;
            end else if (!r_reported) begin
                r_seen     <= n_seen;
                r_reported <= hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_fire && !r_reported && (hit || r_in.region_last)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire && !r_reported) begin
            if (hit) begin
                r_out.found        <= 1'b1;
                r_out.match_offset <= diff[MATCH_OFFSET_W-1:0];
            end else if (r_in.region_last) begin
                r_out.found        <= 1'b0;
                r_out.match_offset <= '0;
            end
        end
    end

`include "wildcard_byte_signature_scan_unit_assert.svh"

    `WBSS_ASSERT_NOW(a_nomatch_zero_offset, i_clk, i_rst_n, o_out_valid && !o_out_data.found, o_out_data.match_offset == '0)
    `WBSS_ASSERT_NEXT(a_last_clears_region, i_clk, i_rst_n, s2_fire && r_in.region_last, !r_reported && (r_seen == '0))
    `WBSS_ASSERT_NEXT(a_reported_sticks, i_clk, i_rst_n, s2_fire && r_reported && !r_in.region_last, r_reported)

endmodule
